FILE: sv/ashm_pkg.sv
// Package for the angle to strip hit mapper: shared types, constants, register
// indexes and the CORDIC arctangent table. No dependencies.
package ashm_pkg;

    localparam int MAX_STRIPS   = 32;
    localparam int MAX_BACKS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int ANG_DROP     = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam logic [15:0] ANG_MASK = 16'hFFFF << ANG_DROP;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 16;
    localparam int DIV_STEPS    = 16;
    localparam int XY_W         = 34;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Register indexes; the byte address of a register is four times its index.
    localparam logic [2:0] REG_DET_AZIMUTH  = 3'd0;
    localparam logic [2:0] REG_DET_RADIUS   = 3'd1;
    localparam logic [2:0] REG_DET_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_STRIP_PITCH  = 3'd3;
    localparam logic [2:0] REG_BACK_PITCH   = 3'd4;
    localparam logic [2:0] REG_STRIP_COUNT  = 3'd5;
    localparam logic [2:0] REG_BACK_COUNT   = 3'd6;
    localparam logic [2:0] REG_UNMAPPED     = 3'd7;

    // Record handed from one trig cell to the next: two CORDIC rotations
    // (azimuth and polar angle) and one integer square root.
    typedef struct packed {
        logic signed [XY_W-1:0] px;
        logic signed [XY_W-1:0] py;
        logic signed [XY_W-1:0] pz;
        logic                   pflip;
        logic signed [XY_W-1:0] tx;
        logic signed [XY_W-1:0] ty;
        logic signed [XY_W-1:0] tz;
        logic                   tflip;
        logic [31:0]            sv;
        logic [31:0]            sr;
        logic                   mode;
        logic signed [15:0]     cos_in;
    } t_trig;

    // Record handed from one divider cell to the next: three restoring
    // divisions that each settle one quotient bit per cell.
    typedef struct packed {
        logic [63:0] rs;
        logic [63:0] ds;
        logic [63:0] rb;
        logic [63:0] db;
        logic [63:0] rr;
        logic [63:0] dr;
        logic [15:0] qs;
        logic [15:0] qb;
        logic [15:0] qr;
        logic        rneg;
        logic        miss;
    } t_div;

    typedef struct packed {
        logic               hit;
        logic [4:0]         strip;
        logic [3:0]         back;
        logic signed [15:0] ratio;
    } t_res;

    function automatic logic signed [XY_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [XY_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/ashm_trig_cell.sv
// One cell of the trig chain: a CORDIC step for each of the two angles and
// one step of the integer square root. Depends on ashm_pkg.
module ashm_trig_cell import ashm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [4:0] i_step,
    input  logic       i_valid,
    input  t_trig      i_rec,
    output logic       o_valid,
    output t_trig      o_rec
);

    logic signed [XY_W-1:0] atan_v;
    logic [31:0]            sq_b;
    logic [31:0]            sq_t;
    t_trig                  n_rec;
    t_trig                  r_rec;
    logic                   r_valid;

    always_comb begin
        atan_v = atan_q30(i_step);
        n_rec  = i_rec;
        if (!i_rec.pz[XY_W-1]) begin
            n_rec.px = i_rec.px - ($signed(i_rec.py) >>> i_step);
            n_rec.py = i_rec.py + ($signed(i_rec.px) >>> i_step);
            n_rec.pz = i_rec.pz - atan_v;
        end else begin
            n_rec.px = i_rec.px + ($signed(i_rec.py) >>> i_step);
            n_rec.py = i_rec.py - ($signed(i_rec.px) >>> i_step);
            n_rec.pz = i_rec.pz + atan_v;
        end
        if (!i_rec.tz[XY_W-1]) begin
            n_rec.tx = i_rec.tx - ($signed(i_rec.ty) >>> i_step);
            n_rec.ty = i_rec.ty + ($signed(i_rec.tx) >>> i_step);
            n_rec.tz = i_rec.tz - atan_v;
        end else begin
            n_rec.tx = i_rec.tx + ($signed(i_rec.ty) >>> i_step);
            n_rec.ty = i_rec.ty - ($signed(i_rec.tx) >>> i_step);
            n_rec.tz = i_rec.tz + atan_v;
        end
        // The square root settles two radicand bits per step and is done
        // after its first sixteen cells.
        sq_b = 32'h4000_0000 >> {i_step, 1'b0};
        sq_t = i_rec.sr + sq_b;
        if (i_step < 5'(SQRT_STEPS)) begin
            if (i_rec.sv >= sq_t) begin
                n_rec.sv = i_rec.sv - sq_t;
                n_rec.sr = (i_rec.sr >> 1) + sq_b;
            end else begin
                n_rec.sr = i_rec.sr >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

FILE: sv/ashm_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the strip,
// back and ratio divisions. Depends on ashm_pkg.
module ashm_div_cell import ashm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [3:0] i_pos,
    input  logic       i_valid,
    input  t_div       i_rec,
    output logic       o_valid,
    output t_div       o_rec
);

    logic [63:0] ds_sh;
    logic [63:0] db_sh;
    logic [63:0] dr_sh;
    t_div        n_rec;
    t_div        r_rec;
    logic        r_valid;

    always_comb begin
        ds_sh = i_rec.ds << i_pos;
        db_sh = i_rec.db << i_pos;
        dr_sh = i_rec.dr << i_pos;
        n_rec = i_rec;
        if (i_rec.rs >= ds_sh) begin
            n_rec.rs = i_rec.rs - ds_sh;
            n_rec.qs = i_rec.qs | (16'd1 << i_pos);
        end
        if (i_rec.rb >= db_sh) begin
            n_rec.rb = i_rec.rb - db_sh;
            n_rec.qb = i_rec.qb | (16'd1 << i_pos);
        end
        if (i_rec.rr >= dr_sh) begin
            n_rec.rr = i_rec.rr - dr_sh;
            n_rec.qr = i_rec.qr | (16'd1 << i_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

FILE: sv/angle_to_strip_hit_mapper.sv
// Top level of the angle to strip hit mapper: configuration registers, input
// stage, product stages, the two cell chains and the output queue.
// Depends on ashm_pkg, ashm_trig_cell and ashm_div_cell.
//
// Usage: each input beat on the s_ channel is one ray (mode in s_tuser,
// polar angle, cos of polar angle and azimuth in s_tdata). Each ray gives
// exactly one output beat on the m_ channel: hit flag in m_tuser, strip
// index, back index and axial ratio in m_tdata. A miss gives all zeros.
// Registers are written over the APB port while no ray is in flight; the
// user is bound to this, the block itself does not enforce it. The input
// stage loads at the accepting edge, then 24 trig cells, a rounding stage,
// four product stages, 16 divider cells and the output queue follow.
// Throughput is one beat per cycle while the output queue is not full, set
// by the chain of cells that every stage advances at once. A two-entry
// output queue holds results while the receiver stalls; the whole pipeline
// freezes only while the queue is full, and s_tready is low exactly then.
// Reset clears all valid bits and the queue and loads the register defaults.
module angle_to_strip_hit_mapper import ashm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // polar_angle[15:0], cos_polar[31:16], azimuth[47:32]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // strip_index[4:0], back_index[8:5], axial_ratio[24:9]
    output logic        m_tuser,   // hit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [15:0]        r_det_azimuth;
    logic [15:0]        r_det_radius;
    logic signed [15:0] r_det_center_z;
    logic [11:0]        r_strip_pitch;
    logic [12:0]        r_back_pitch;
    logic [5:0]         r_strip_count;
    logic [4:0]         r_back_count;

    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_azimuth  <= 16'd0;
            r_det_radius   <= 16'd1000;
            r_det_center_z <= 16'sd0;
            r_strip_pitch  <= 12'd100;
            r_back_pitch   <= 13'd500;
            r_strip_count  <= 6'd16;
            r_back_count   <= 5'd4;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_DET_AZIMUTH:  r_det_azimuth  <= pwdata[15:0];
                REG_DET_RADIUS:   r_det_radius   <= pwdata[15:0];
                REG_DET_CENTER_Z: r_det_center_z <= pwdata[15:0];
                REG_STRIP_PITCH:  r_strip_pitch  <= pwdata[11:0];
                REG_BACK_PITCH:   r_back_pitch   <= pwdata[12:0];
                REG_STRIP_COUNT:  r_strip_count  <= pwdata[5:0];
                REG_BACK_COUNT:   r_back_count   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DET_AZIMUTH:  prdata = {16'd0, r_det_azimuth};
            REG_DET_RADIUS:   prdata = {16'd0, r_det_radius};
            REG_DET_CENTER_Z: prdata = {16'd0, r_det_center_z};
            REG_STRIP_PITCH:  prdata = {20'd0, r_strip_pitch};
            REG_BACK_PITCH:   prdata = {19'd0, r_back_pitch};
            REG_STRIP_COUNT:  prdata = {26'd0, r_strip_count};
            REG_BACK_COUNT:   prdata = {27'd0, r_back_count};
            default:          prdata = 32'd0;
        endcase
    end

    // Derived detector geometry, refreshed every cycle from the registers.
    logic [5:0]  n_ns;
    logic [4:0]  n_nb;
    logic [5:0]  r_ns;
    logic [4:0]  r_nb;
    logic [16:0] r_w;
    logic [16:0] r_len;
    logic        r_cfg_bad;

    assign n_ns = (r_strip_count > 6'(MAX_STRIPS)) ? 6'(MAX_STRIPS) : r_strip_count;
    assign n_nb = (r_back_count > 5'(MAX_BACKS)) ? 5'(MAX_BACKS) : r_back_count;

    always_ff @(posedge i_clk) begin
        r_ns      <= n_ns;
        r_nb      <= n_nb;
        r_w       <= 17'(r_strip_pitch * n_ns);
        r_len     <= 17'(r_back_pitch * n_nb);
        r_cfg_bad <= (n_ns == 6'd0) | (n_nb == 5'd0) | (r_strip_pitch == 12'd0)
                   | (r_back_pitch == 13'd0);
    end

    // Pipeline advance and output queue state
    logic [1:0] r_cnt;
    logic       adv;
    assign adv      = (r_cnt != 2'd2);
    assign s_tready = adv;

    // Input stage: phases, quadrant folding and the square root radicand.
    logic [31:0]        ph_phi;
    logic [31:0]        ph_th;
    logic [31:0]        phi_plus;
    logic [31:0]        th_plus;
    logic [31:0]        phi_rot;
    logic [31:0]        th_rot;
    logic signed [15:0] cos_in;
    logic signed [31:0] cos_sq;
    t_trig              n_trig0;
    t_trig              r_trig0;
    logic               r_v0;

    always_comb begin
        ph_phi   = {(s_tdata[47:32] - r_det_azimuth) & ANG_MASK, 16'h0000};
        ph_th    = {s_tdata[15:0] & ANG_MASK, 16'h0000};
        phi_plus = ph_phi + 32'h4000_0000;
        th_plus  = ph_th + 32'h4000_0000;
        phi_rot  = phi_plus[31] ? ph_phi + 32'h8000_0000 : ph_phi;
        th_rot   = th_plus[31] ? ph_th + 32'h8000_0000 : ph_th;
        cos_in   = s_tdata[31:16];
        cos_sq   = cos_in * cos_in;

        n_trig0.px     = CORDIC_GAIN;
        n_trig0.py     = '0;
        n_trig0.pz     = XY_W'($signed(phi_rot));
        n_trig0.pflip  = phi_plus[31];
        n_trig0.tx     = CORDIC_GAIN;
        n_trig0.ty     = '0;
        n_trig0.tz     = XY_W'($signed(th_rot));
        n_trig0.tflip  = th_plus[31];
        n_trig0.sv     = 32'h4000_0000 - cos_sq;
        n_trig0.sr     = 32'd0;
        n_trig0.mode   = s_tuser;
        n_trig0.cos_in = cos_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_trig0 <= n_trig0;
        end
    end

    // Trig chain
    t_trig trig_rec [0:CORDIC_STEPS];
    logic  trig_v   [0:CORDIC_STEPS];
    assign trig_rec[0] = r_trig0;
    assign trig_v[0]   = r_v0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_trig
        ashm_trig_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_step  (5'(k)),
            .i_valid (trig_v[k]),
            .i_rec   (trig_rec[k]),
            .o_valid (trig_v[k+1]),
            .o_rec   (trig_rec[k+1])
        );
    end

    // Rounding to Q15 and source selection for the polar angle.
    t_trig                  tr;
    logic signed [XY_W-1:0] pxr, pyr, txr, tyr;
    logic signed [XY_W-1:0] cp_c, sp_c, ct_c, st_c;
    logic signed [17:0]     r_cp, r_sp, r_ct, r_st;
    logic                   r_vp;

    always_comb begin
        tr   = trig_rec[CORDIC_STEPS];
        pxr  = ($signed(tr.px) + 34'sd16384) >>> 15;
        pyr  = ($signed(tr.py) + 34'sd16384) >>> 15;
        txr  = ($signed(tr.tx) + 34'sd16384) >>> 15;
        tyr  = ($signed(tr.ty) + 34'sd16384) >>> 15;
        cp_c = tr.pflip ? -pxr : pxr;
        sp_c = tr.pflip ? -pyr : pyr;
        ct_c = tr.tflip ? -txr : txr;
        st_c = tr.tflip ? -tyr : tyr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (adv) begin
            r_vp <= trig_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cp <= cp_c[17:0];
            r_sp <= sp_c[17:0];
            r_ct <= tr.mode ? 18'(tr.cos_in) : ct_c[17:0];
            r_st <= tr.mode ? {2'b00, tr.sr[15:0]} : st_c[17:0];
        end
    end

    // First products
    logic signed [17:0] rho_s;
    logic signed [17:0] w_s;
    logic signed [35:0] r1_ysp, r1_wcp, r1_rct, r1_dz;
    logic [29:0]        r1_sden;
    logic               r1_miss;
    logic               r_v1;

    assign rho_s = {2'b00, r_det_radius};
    assign w_s   = {1'b0, r_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ysp  <= rho_s * r_sp;
            r1_wcp  <= w_s * r_cp;
            r1_rct  <= rho_s * r_ct;
            r1_dz   <= r_cp * r_st;
            r1_sden <= 30'({r_strip_pitch, 1'b0} * r_cp[16:0]);
            r1_miss <= (r_cp <= 18'sd0) | (r_st == 18'sd0);
        end
    end

    // Width test, sign fix of the denominator, second products
    logic signed [35:0] aysp;
    logic signed [37:0] aysp2;
    logic signed [35:0] dz_abs;
    logic [30:0]        dzp;
    logic signed [47:0] r2_czdz;
    logic [47:0]        r2_lendz;
    logic [44:0]        r2_bden;
    logic signed [35:0] r2_nzs;
    logic signed [37:0] r2_snum;
    logic [29:0]        r2_sden;
    logic               r2_miss;
    logic               r_v2;

    always_comb begin
        aysp   = r1_ysp[35] ? -r1_ysp : r1_ysp;
        aysp2  = 38'(aysp) <<< 1;
        dz_abs = r1_dz[35] ? -r1_dz : r1_dz;
        dzp    = dz_abs[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_czdz  <= r_det_center_z * $signed({1'b0, dzp});
            r2_lendz <= 48'(r_len * dzp);
            r2_bden  <= 45'({r_back_pitch, 1'b0} * dzp);
            r2_nzs   <= r1_dz[35] ? -r1_rct : r1_rct;
            r2_snum  <= (38'(r1_ysp) <<< 1) + 38'(r1_wcp);
            r2_sden  <= r1_sden;
            r2_miss  <= r1_miss | (aysp2 > 38'(r1_wcp));
        end
    end

    // Axial window bounds
    logic signed [55:0] nz2_c, czdz2_c, lendz_c;
    logic signed [55:0] r3_nz2, r3_czdz2, r3_lo, r3_hi;
    logic [47:0]        r3_lendz;
    logic [44:0]        r3_bden;
    logic signed [37:0] r3_snum;
    logic [29:0]        r3_sden;
    logic               r3_miss;
    logic               r_v3;

    always_comb begin
        nz2_c   = 56'(r2_nzs) <<< 16;
        czdz2_c = 56'(r2_czdz) <<< 1;
        lendz_c = $signed({8'd0, r2_lendz});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_nz2   <= nz2_c;
            r3_czdz2 <= czdz2_c;
            r3_lo    <= czdz2_c - lendz_c;
            r3_hi    <= czdz2_c + lendz_c;
            r3_lendz <= r2_lendz;
            r3_bden  <= r2_bden;
            r3_snum  <= r2_snum;
            r3_sden  <= r2_sden;
            r3_miss  <= r2_miss;
        end
    end

    // Window test and divider operands
    logic signed [55:0] bnum;
    logic signed [55:0] rdiff;
    logic signed [55:0] rabs;
    t_div               n_div0;
    t_div               r_div0;
    logic               r_v4;

    always_comb begin
        bnum        = r3_nz2 - r3_lo;
        rdiff       = r3_nz2 - r3_czdz2;
        rabs        = rdiff[55] ? -rdiff : rdiff;
        n_div0.rs   = {26'd0, r3_snum[37:0]};
        n_div0.ds   = {34'd0, r3_sden};
        n_div0.rb   = {8'd0, bnum[55:0]};
        n_div0.db   = {19'd0, r3_bden};
        n_div0.rr   = {rabs[48:0], 15'd0};
        n_div0.dr   = {16'd0, r3_lendz};
        n_div0.qs   = 16'd0;
        n_div0.qb   = 16'd0;
        n_div0.qr   = 16'd0;
        n_div0.rneg = rdiff[55];
        n_div0.miss = r3_miss | (r3_nz2 < r3_lo) | (r3_nz2 > r3_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_div0 <= n_div0;
        end
    end

    // Divider chain, most significant quotient bit first
    t_div div_rec [0:DIV_STEPS];
    logic div_v   [0:DIV_STEPS];
    assign div_rec[0] = r_div0;
    assign div_v[0]   = r_v4;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        ashm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_pos   (4'(DIV_STEPS - 1 - k)),
            .i_valid (div_v[k]),
            .i_rec   (div_rec[k]),
            .o_valid (div_v[k+1]),
            .o_rec   (div_rec[k+1])
        );
    end

    // Far-edge clamp, ratio sign and saturation, miss blanking.
    t_div               dq;
    logic [15:0]        s_cl;
    logic [15:0]        b_cl;
    logic signed [16:0] r_negv;
    logic signed [15:0] ratio;
    t_res               res;

    always_comb begin
        dq     = div_rec[DIV_STEPS];
        s_cl   = (dq.qs >= 16'(r_ns)) ? 16'(r_ns) - 16'd1 : dq.qs;
        b_cl   = (dq.qb >= 16'(r_nb)) ? 16'(r_nb) - 16'd1 : dq.qb;
        r_negv = -$signed({1'b0, dq.qr});
        if (dq.rneg) begin
            ratio = r_negv[15:0];
        end else if (dq.qr > 16'd32767) begin
            ratio = 16'sh7FFF;
        end else begin
            ratio = dq.qr;
        end
        if (dq.miss | r_cfg_bad) begin
            res = '0;
        end else begin
            res.hit   = 1'b1;
            res.strip = s_cl[4:0];
            res.back  = b_cl[3:0];
            res.ratio = ratio;
        end
    end

    // Two-entry output queue
    t_res r_q0;
    t_res r_q1;
    logic push;
    logic pop;

    assign push = adv & div_v[DIV_STEPS];
    assign pop  = (r_cnt != 2'd0) & m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_q0 <= res;
                end else begin
                    r_q1 <= res;
                end
            end
            2'b01: begin
                r_q0 <= r_q1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_q0 <= res;
                end else begin
                    r_q0 <= r_q1;
                    r_q1 <= res;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = (r_cnt != 2'd0);
    assign m_tdata  = {7'd0, r_q0.ratio, r_q0.back, r_q0.strip};
    assign m_tuser  = r_q0.hit;

endmodule
